// ===== hw/rtl/b64enc_pkg.sv =====
// Shared types, item codes and the standard alphabet for the Base64 stream encoder.
package b64enc_pkg;

   localparam int unsigned KindWidth  = 2;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned SymWidth   = 6;
   localparam int unsigned AlphaDepth = 64;

   // Input transaction kinds carried on tuser.
   localparam logic [KindWidth-1:0] KIND_DATA    = 2'd0;
   localparam logic [KindWidth-1:0] KIND_FINISH  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_TABLE   = 2'd2;
   localparam logic [KindWidth-1:0] KIND_RESTART = 2'd3;

   // Position within the current three-byte group.
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   // What one accepted transaction asks of the output sequencer.
   typedef struct packed {
      logic [1:0] count;       // number of characters to send, 0 to 3
      logic       sec_alpha;   // second character is an alphabet lookup, not a pad
   } plan_type;

   // Standard alphabet: A-Z a-z 0-9 + /
   function automatic logic [CharWidth-1:0] std_char(input logic [SymWidth-1:0] idx);
      logic [CharWidth-1:0] ext;
      logic [CharWidth-1:0] ch;
      ext = {2'b00, idx};
      if (idx < 6'd26) begin
         ch = 8'h41 + ext;
      end else if (idx < 6'd52) begin
         ch = 8'h61 + ext - 8'd26;
      end else if (idx < 6'd62) begin
         ch = 8'h30 + ext - 8'd52;
      end else if (idx == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

// ===== hw/rtl/b64enc_sym_mem.sv =====
// Alphabet memory with one write port, two registered read ports and reset-to-standard valid bits.
module b64enc_sym_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [b64enc_pkg::SymWidth-1:0]     wr_addr,
   input  logic [b64enc_pkg::CharWidth-1:0]    wr_data,
   input  logic                                rd_en,
   input  logic [b64enc_pkg::SymWidth-1:0]     rd_addr0,
   input  logic [b64enc_pkg::SymWidth-1:0]     rd_addr1,
   output logic [b64enc_pkg::CharWidth-1:0]    rd_char0,
   output logic [b64enc_pkg::CharWidth-1:0]    rd_char1
);

   logic [b64enc_pkg::CharWidth-1:0]  alpha_mem [b64enc_pkg::AlphaDepth];
   logic [b64enc_pkg::AlphaDepth-1:0] valid_ff;
   logic [b64enc_pkg::AlphaDepth-1:0] valid_in;
   logic [b64enc_pkg::CharWidth-1:0]  rd_data0_ff;
   logic [b64enc_pkg::CharWidth-1:0]  rd_data1_ff;
   logic [b64enc_pkg::SymWidth-1:0]   rd_addr0_ff;
   logic [b64enc_pkg::SymWidth-1:0]   rd_addr1_ff;
   logic                              rd_vld0_ff;
   logic                              rd_vld1_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         alpha_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= alpha_mem[rd_addr0];
         rd_data1_ff <= alpha_mem[rd_addr1];
         rd_addr0_ff <= rd_addr0;
         rd_addr1_ff <= rd_addr1;
         rd_vld0_ff  <= valid_ff[rd_addr0];
         rd_vld1_ff  <= valid_ff[rd_addr1];
      end
   end

   // An entry never written since reset still holds its standard character.
   assign rd_char0 = rd_vld0_ff ? rd_data0_ff : b64enc_pkg::std_char(rd_addr0_ff);
   assign rd_char1 = rd_vld1_ff ? rd_data1_ff : b64enc_pkg::std_char(rd_addr1_ff);

endmodule

// ===== hw/rtl/b64enc_group.sv =====
// Group state (phase and leftover bits) and the decode of one input transaction.
module b64enc_group (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [b64enc_pkg::KindWidth-1:0]    kind,
   input  logic [7:0]                          data_byte,
   input  logic                                pad_on,
   output logic [b64enc_pkg::SymWidth-1:0]     sym0,
   output logic [b64enc_pkg::SymWidth-1:0]     sym1,
   output b64enc_pkg::plan_type                plan
);

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [3:0] left_ff;
   logic [3:0] left_in;

   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      sym0           = data_byte[7:2];
      sym1           = data_byte[5:0];
      plan.count     = 2'd0;
      plan.sec_alpha = 1'b0;
      unique case (kind)
         b64enc_pkg::KIND_DATA: begin
            if (phase_ff == b64enc_pkg::PHASE_1) begin
               sym0       = {left_ff[1:0], data_byte[7:4]};
               plan.count = 2'd1;
               left_in    = data_byte[3:0];
               phase_in   = b64enc_pkg::PHASE_2;
            end else if (phase_ff == b64enc_pkg::PHASE_2) begin
               sym0           = {left_ff, data_byte[7:6]};
               plan.count     = 2'd2;
               plan.sec_alpha = 1'b1;
               left_in        = 4'd0;
               phase_in       = b64enc_pkg::PHASE_0;
            end else begin
               // The unused phase code behaves like the start of a group.
               plan.count = 2'd1;
               left_in    = {2'b00, data_byte[1:0]};
               phase_in   = b64enc_pkg::PHASE_1;
            end
         end
         b64enc_pkg::KIND_FINISH: begin
            if (phase_ff == b64enc_pkg::PHASE_1) begin
               sym0       = {left_ff[1:0], 4'd0};
               plan.count = pad_on ? 2'd3 : 2'd1;
            end else if (phase_ff == b64enc_pkg::PHASE_2) begin
               sym0       = {left_ff, 2'd0};
               plan.count = pad_on ? 2'd2 : 2'd1;
            end
            left_in  = 4'd0;
            phase_in = b64enc_pkg::PHASE_0;
         end
         b64enc_pkg::KIND_TABLE: begin
         end
         b64enc_pkg::KIND_RESTART: begin
            left_in  = 4'd0;
            phase_in = b64enc_pkg::PHASE_0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64enc_pkg::PHASE_0;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== hw/rtl/b64enc_emit.sv =====
// Character sequencer for one transaction's results and the registered output stage.
module b64enc_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  b64enc_pkg::plan_type                plan,
   input  logic [b64enc_pkg::CharWidth-1:0]    char0,
   input  logic [b64enc_pkg::CharWidth-1:0]    char1,
   input  logic [b64enc_pkg::CharWidth-1:0]    pad_char,
   output logic                                can_load,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [b64enc_pkg::CharWidth-1:0]    out_char,
   output logic                                out_last
);

   logic [1:0]                        cnt_ff;
   logic [1:0]                        cnt_in;
   logic [1:0]                        pos_ff;
   logic [1:0]                        pos_in;
   logic                              sec_ff;
   logic                              sec_in;
   logic                              out_vld_ff;
   logic                              out_vld_in;
   logic [b64enc_pkg::CharWidth-1:0]  out_char_ff;
   logic                              out_last_ff;
   logic [b64enc_pkg::CharWidth-1:0]  cur_char;
   logic                              move;

   assign move     = (cnt_ff != 2'd0) && (!out_vld_ff || out_ready);
   // A new transaction may enter once the last pending character leaves this cycle.
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && move);

   always_comb begin
      unique case (pos_ff)
         2'd0:    cur_char = char0;
         2'd1:    cur_char = sec_ff ? char1 : pad_char;
         default: cur_char = pad_char;
      endcase
   end

   always_comb begin
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      sec_in     = sec_ff;
      out_vld_in = out_vld_ff;
      if (move) begin
         cnt_in     = cnt_ff - 2'd1;
         pos_in     = pos_ff + 2'd1;
         out_vld_in = 1'b1;
      end else if (out_ready) begin
         out_vld_in = 1'b0;
      end
      if (load) begin
         cnt_in = plan.count;
         pos_in = 2'd0;
         sec_in = plan.sec_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 2'd0;
         pos_ff     <= 2'd0;
         sec_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         sec_ff     <= sec_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_char_ff <= cur_char;
         out_last_ff <= (cnt_ff == 2'd1);
      end
   end

   assign out_valid = out_vld_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== hw/rtl/base64_stream_encoder_top.sv =====
// Top level of the Base64 stream encoder with programmable alphabet and pad character.
//
// The encoder takes one transaction per cycle on the request channel whenever its character
// buffer is empty or about to empty: data bytes, finish marks, alphabet entry writes and
// restarts. Each data byte yields one character, or two on the third byte of a group, and a
// finish emits the partial group followed by up to two pad characters (none when the pad
// register holds zero). Characters leave one per cycle while rsp_tready holds, through a
// registered response stage, with tlast on the final character of each transaction that
// yields characters, so a byte stream is bound by the one-character output port (4 bytes of
// output per 3 input bytes). The alphabet comes up as the standard set after reset with no
// initialization writes needed; alphabet writes and pad register writes must be issued
// while no characters are pending.
module base64_stream_encoder_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,  // data_byte [7:0], table_index [13:8], table_char [21:14]
   input  logic [1:0]   req_tuser,  // kind [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // out_char [7:0]
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [7:0]   csr_wdata
);

   logic                              accept;
   logic [b64enc_pkg::CharWidth-1:0]  pad_ff;
   logic [b64enc_pkg::SymWidth-1:0]   sym0;
   logic [b64enc_pkg::SymWidth-1:0]   sym1;
   logic [b64enc_pkg::CharWidth-1:0]  char0;
   logic [b64enc_pkg::CharWidth-1:0]  char1;
   b64enc_pkg::plan_type              plan;
   logic                              can_load;
   logic                              table_wr;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;
   assign table_wr   = accept && (req_tuser == b64enc_pkg::KIND_TABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= 8'h3D;
      end else if (csr_wen) begin
         pad_ff <= csr_wdata;
      end
   end

   b64enc_group u_group (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_tuser),
      .data_byte (req_tdata[7:0]),
      .pad_on    (pad_ff != 8'd0),
      .sym0      (sym0),
      .sym1      (sym1),
      .plan      (plan)
   );

   b64enc_sym_mem u_sym_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (table_wr),
      .wr_addr  (req_tdata[13:8]),
      .wr_data  (req_tdata[21:14]),
      .rd_en    (accept),
      .rd_addr0 (sym0),
      .rd_addr1 (sym1),
      .rd_char0 (char0),
      .rd_char1 (char1)
   );

   b64enc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .plan      (plan),
      .char0     (char0),
      .char1     (char1),
      .pad_char  (pad_ff),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule
